[hw/rtl/pli_pkg.sv]
package pli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DATA_W      = 32;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [DATA_W-1:0] point_pos;
        logic [DATA_W-1:0] point_value;
    } t_cmd;

endpackage

[hw/rtl/piecewise_linear_interpolator_unit.sv]
// channel  | dir | payload
// s_axis   | in  | tdata: point_pos [31:0], point_value [63:32]; tuser: action [1:0]
// m_axis   | out | tdata: interp_value [31:0]; tuser: in_range [0], table_overflow [1]
//
// the back end does clear and append while idle; a query reads one table entry per cycle.
// the result registers at the end of the scan when no segment encloses the position, after
// S_PREP and S_MAG on a zero-width segment, and after S_PREP, S_MAG, S_MUL, S_DSTART and the
// 32-step bit-serial divider when interpolating; an empty table answers at the accepting edge.
// a four-word command queue takes input words while a query runs; a query waits there while
// an unread result holds the output register. reset (synchronous, active low) empties all.
module piecewise_linear_interpolator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // point_pos, point_value
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // interp_value
    output logic [1:0]  m_axis_tuser   // in_range, table_overflow
);

    logic          cmd_valid;
    logic          cmd_ready;
    pli_pkg::t_cmd cmd;

    pli_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd)
    );

    pli_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_ready  (cmd_ready),
        .i_cmd        (cmd),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

[hw/rtl/pli_ram.sv]
module pli_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pli_div.sv]
module pli_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [2*pli_pkg::DATA_W-1:0] i_dividend,
    input  logic [pli_pkg::DATA_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [pli_pkg::DATA_W-1:0]   o_quotient
);

    localparam int STEP_W = $clog2(pli_pkg::DATA_W);

    logic                         r_busy;
    logic                         r_done;
    logic [STEP_W-1:0]            r_step;
    logic [pli_pkg::DATA_W-1:0]   r_rem;
    logic [pli_pkg::DATA_W-1:0]   r_shift;
    logic [pli_pkg::DATA_W-1:0]   r_divisor;

    logic [pli_pkg::DATA_W:0]     trial;
    logic [pli_pkg::DATA_W:0]     diff;
    logic                         qbit;

    // high half of the dividend is below the divisor, so the quotient fits one word
    always_comb begin
        trial = {r_rem, r_shift[pli_pkg::DATA_W-1]};
        diff  = trial - {1'b0, r_divisor};
        qbit  = !diff[pli_pkg::DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(pli_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_dividend[2*pli_pkg::DATA_W-1:pli_pkg::DATA_W];
            r_shift   <= i_dividend[pli_pkg::DATA_W-1:0];
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem   <= qbit ? diff[pli_pkg::DATA_W-1:0] : trial[pli_pkg::DATA_W-1:0];
            r_shift <= {r_shift[pli_pkg::DATA_W-2:0], qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_shift;

endmodule

[hw/rtl/pli_front.sv]
module pli_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [2*pli_pkg::DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]                 s_axis_tuser,
    output logic                       o_cmd_valid,
    input  logic                       i_cmd_ready,
    output pli_pkg::t_cmd              o_cmd
);

    pli_pkg::t_cmd                 r_queue [pli_pkg::QUEUE_DEPTH];
    logic [pli_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [pli_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [pli_pkg::QCNT_W-1:0]    r_fill;

    logic                          take;
    logic                          push;
    logic                          pop;
    pli_pkg::t_cmd                 in_cmd;

    assign s_axis_tready = (r_fill != pli_pkg::QCNT_W'(pli_pkg::QUEUE_DEPTH));
    assign take          = s_axis_tvalid && s_axis_tready;
    // unused action code is dropped here
    assign push          = take && (s_axis_tuser != pli_pkg::ACT_NONE);
    assign pop           = o_cmd_valid && i_cmd_ready;

    assign in_cmd.action      = s_axis_tuser;
    assign in_cmd.point_pos   = s_axis_tdata[pli_pkg::DATA_W-1:0];
    assign in_cmd.point_value = s_axis_tdata[2*pli_pkg::DATA_W-1:pli_pkg::DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + pli_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + pli_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + pli_pkg::QCNT_W'(1);
            end else if (!push && pop) begin
                r_fill <= r_fill - pli_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_cmd;
        end
    end

    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

endmodule

[hw/rtl/pli_back.sv]
module pli_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  pli_pkg::t_cmd                i_cmd,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pli_pkg::DATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                   m_axis_tuser
);

    localparam int DW  = pli_pkg::DATA_W;
    localparam int IW  = pli_pkg::IDX_W;
    localparam int CW  = pli_pkg::CNT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_MAG    = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [IW-1:0]   r_addr, n_addr;
    logic [DW-1:0]   r_pos, n_pos;
    logic [DW-1:0]   r_px, n_px;
    logic [DW-1:0]   r_pv, n_pv;
    logic [DW-1:0]   r_x1, n_x1;
    logic [DW-1:0]   r_v1, n_v1;
    logic [DW-1:0]   r_span, n_span;
    logic [DW-1:0]   r_offs, n_offs;
    logic [DW:0]     r_dv, n_dv;
    logic [DW-1:0]   r_mag, n_mag;
    logic            r_neg, n_neg;
    logic [2*DW-1:0] r_prod, n_prod;
    logic            r_out_valid, n_out_valid;
    logic [DW-1:0]   r_out_value, n_out_value;
    logic            r_out_range, n_out_range;
    logic            r_out_ovf, n_out_ovf;

    logic            ram_we;
    logic [IW-1:0]   ram_raddr;
    logic [2*DW-1:0] ram_rdata;
    logic [DW-1:0]   rx;
    logic [DW-1:0]   rv;
    logic            out_free;
    logic            seg_hit;
    logic            seg_last;
    logic            div_start;
    logic            div_done;
    logic [DW-1:0]   div_quo;

    pli_ram #(
        .W(2 * DW),
        .D(pli_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[IW-1:0]),
        .i_wdata({i_cmd.point_pos, i_cmd.point_value}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    pli_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_prod),
        .i_divisor (r_span),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    assign rx       = ram_rdata[2*DW-1:DW];
    assign rv       = ram_rdata[DW-1:0];
    assign out_free = !r_out_valid || m_axis_tready;
    assign seg_hit  = (r_addr != '0) && ($signed(r_pos) >= $signed(r_px))
                      && ($signed(r_pos) <= $signed(rx));
    assign seg_last = ({1'b0, r_addr} == (r_count - CW'(1)));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_addr      = r_addr;
        n_pos       = r_pos;
        n_px        = r_px;
        n_pv        = r_pv;
        n_x1        = r_x1;
        n_v1        = r_v1;
        n_span      = r_span;
        n_offs      = r_offs;
        n_dv        = r_dv;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_value = r_out_value;
        n_out_range = r_out_range;
        n_out_ovf   = r_out_ovf;
        o_cmd_ready = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = '0;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.action)
                        pli_pkg::ACT_CLEAR: begin
                            o_cmd_ready = 1'b1;
                            n_count     = '0;
                        end
                        pli_pkg::ACT_APPEND: begin
                            o_cmd_ready = 1'b1;
                            if (r_count < CW'(pli_pkg::TABLE_DEPTH)) begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        pli_pkg::ACT_QUERY: begin
                            if (out_free) begin
                                o_cmd_ready = 1'b1;
                                n_pos       = i_cmd.point_pos;
                                if (r_count == '0) begin
                                    n_out_valid = 1'b1;
                                    n_out_value = '0;
                                    n_out_range = 1'b0;
                                    n_out_ovf   = r_ovf;
                                end else begin
                                    ram_raddr = '0;
                                    n_addr    = '0;
                                    n_state   = S_SCAN;
                                end
                            end
                        end
                        default: begin
                            o_cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (seg_hit) begin
                    n_x1    = rx;
                    n_v1    = rv;
                    n_state = S_PREP;
                end else if (seg_last) begin
                    n_out_valid = 1'b1;
                    n_out_value = rv;
                    n_out_range = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_state     = S_IDLE;
                end else begin
                    n_px      = rx;
                    n_pv      = rv;
                    ram_raddr = r_addr + IW'(1);
                    n_addr    = ram_raddr;
                end
            end
            S_PREP: begin
                n_span  = r_x1 - r_px;
                n_offs  = r_pos - r_px;
                n_dv    = {r_v1[DW-1], r_v1} - {r_pv[DW-1], r_pv};
                n_state = S_MAG;
            end
            S_MAG: begin
                if (r_span == '0) begin
                    // zero-width segment gives its left value
                    n_out_valid = 1'b1;
                    n_out_value = r_pv;
                    n_out_range = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_state     = S_IDLE;
                end else begin
                    n_neg   = r_dv[DW];
                    n_mag   = r_dv[DW] ? DW'(-r_dv) : r_dv[DW-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = {{DW{1'b0}}, r_offs} * {{DW{1'b0}}, r_mag};
                n_state = S_DSTART;
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_neg ? (r_pv - div_quo) : (r_pv + div_quo);
                    n_out_range = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pos       <= n_pos;
        r_px        <= n_px;
        r_pv        <= n_pv;
        r_x1        <= n_x1;
        r_v1        <= n_v1;
        r_span      <= n_span;
        r_offs      <= n_offs;
        r_dv        <= n_dv;
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_prod      <= n_prod;
        r_out_value <= n_out_value;
        r_out_range <= n_out_range;
        r_out_ovf   <= n_out_ovf;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = {r_out_ovf, r_out_range};

endmodule
